// ===== rtl/core/dmx_pkg.sv =====
// Package: shared types and constants of the differential drive duty mixer.
package dmx_pkg;

    localparam int DMX_DUTY_BITS  = 8;
    localparam int DMX_LANES      = 2;
    localparam int DMX_DIV_STEPS  = 4;
    localparam int DMX_CFG_IDX_W  = 1;
    localparam int DMX_ONE_Q12    = 4096;
    localparam int DMX_SPD_W      = 35;
    localparam int DMX_MAG_W      = 13;
    localparam int DMX_PWR_W      = 14;

    localparam logic [15:0] DMX_BASE_RST   = 16'd3604;
    localparam logic [15:0] DMX_RADIUS_RST = 16'd3801;

    typedef enum logic [DMX_CFG_IDX_W-1:0] {
        REG_WHEEL_BASE   = 1'b0,
        REG_WHEEL_RADIUS = 1'b1
    } dmx_reg_t;

    typedef enum logic [2:0] {
        ACT_MOVE  = 3'd0,
        ACT_FWD   = 3'd1,
        ACT_BWD   = 3'd2,
        ACT_LEFT  = 3'd3,
        ACT_RIGHT = 3'd4,
        ACT_STOP  = 3'd5
    } dmx_action_t;

    typedef struct packed {
        logic [2:0]                  action;
        logic signed [DMX_PWR_W-1:0] pwr;
        logic [DMX_LANES-1:0]        neg;
    } dmx_sb1_t;

    typedef struct packed {
        dmx_sb1_t             cmd;
        logic                 scale;
        logic [DMX_MAG_W-1:0] raw_l;
        logic [DMX_MAG_W-1:0] raw_r;
    } dmx_sb2_t;

endpackage

// ===== rtl/core/dmx_cmd_if.sv =====
// Interface: command channel.
interface dmx_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
    logic signed [15:0] power;

    modport source (output valid, action, linear_speed, turn_rate, power, input ready);
    modport sink   (input valid, action, linear_speed, turn_rate, power, output ready);
endinterface

// ===== rtl/core/dmx_duty_if.sv =====
// Interface: duty result channel.
interface dmx_duty_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_forward_duty;
    logic [7:0] left_backward_duty;
    logic [7:0] right_forward_duty;
    logic [7:0] right_backward_duty;

    modport source (output valid, left_forward_duty, left_backward_duty,
                    right_forward_duty, right_backward_duty, input ready);
    modport sink   (input valid, left_forward_duty, left_backward_duty,
                    right_forward_duty, right_backward_duty, output ready);
endinterface

// ===== rtl/core/dmx_cfg_if.sv =====
// Interface: configuration write channel.
interface dmx_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dmx_div.sv =====
// Pipelined two-lane restoring divider with a shared divisor and sideband.
module dmx_div #(
    parameter int DEN_W = 16,
    parameter int Q_W   = 16,
    parameter int STEPS = 4,
    parameter int SB_W  = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DEN_W-1:0] in_den,
    input  logic [DEN_W-1:0] in_rem  [dmx_pkg::DMX_LANES],
    input  logic [Q_W-1:0]   in_low  [dmx_pkg::DMX_LANES],
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_quo [dmx_pkg::DMX_LANES],
    output logic [SB_W-1:0]  out_sb
);
    import dmx_pkg::*;

    localparam int NSTG = (Q_W + STEPS - 1) / STEPS;

    logic             vld_q  [NSTG+1];
    logic [DEN_W-1:0] den_q  [NSTG+1];
    logic [SB_W-1:0]  sb_q   [NSTG+1];
    logic [DEN_W-1:0] rem_q  [NSTG+1][DMX_LANES];
    logic [Q_W-1:0]   work_q [NSTG+1][DMX_LANES];

    assign vld_q[0] = in_valid;
    assign den_q[0] = in_den;
    assign sb_q[0]  = in_sb;

    for (genvar l = 0; l < DMX_LANES; l++)
    begin : g_in
        assign rem_q[0][l]  = in_rem[l];
        assign work_q[0][l] = in_low[l];
        assign out_quo[l]   = work_q[NSTG][l];
    end

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stg
        logic [DEN_W-1:0] rem_next  [DMX_LANES];
        logic [Q_W-1:0]   work_next [DMX_LANES];

        always_comb
        begin
            logic [DEN_W:0]   t;
            logic [DEN_W-1:0] r;
            logic [Q_W-1:0]   w;
            for (int l = 0; l < DMX_LANES; l++)
            begin
                r = rem_q[s][l];
                w = work_q[s][l];
                for (int i = 0; i < STEPS; i++)
                begin
                    if (s * STEPS + i < Q_W)
                    begin
                        t = {r, w[Q_W-1]};
                        w = {w[Q_W-2:0], 1'b0};
                        if (t >= {1'b0, den_q[s]})
                        begin
                            t    = t - {1'b0, den_q[s]};
                            w[0] = 1'b1;
                        end
                        r = t[DEN_W-1:0];
                    end
                end
                rem_next[l]  = r;
                work_next[l] = w;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_q[s+1] <= 1'b0;
            else if (en)
                vld_q[s+1] <= vld_q[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_q[s+1] <= den_q[s];
                sb_q[s+1]  <= sb_q[s];
                for (int l = 0; l < DMX_LANES; l++)
                begin
                    rem_q[s+1][l]  <= rem_next[l];
                    work_q[s+1][l] <= work_next[l];
                end
            end
        end
    end

    assign out_valid = vld_q[NSTG];
    assign out_sb    = sb_q[NSTG];

endmodule

// ===== rtl/core/differential_drive_duty_mixer.sv =====
// Top level: differential drive command to H-bridge duty mixer.
//
// Channels: cmd (sink) takes one command beat per cycle while cmd.ready is
// high; duty (source) returns one beat of four duties per command, in
// order; cfg (sink) writes wheel_base (index 0) or wheel_radius (index 1)
// and is always ready. The pipeline has 18 register stages: 3 input and
// multiply stages, 9 stages of the speed divider (35 quotient bits, 4 per
// stage), one max/compare stage, 4 stages of the normalize divider (13
// quotient bits) and the duty output register.
// Throughput is one command per cycle while duty.ready does not stall the
// pipeline; the divider stage count sets the latency, the 4-bit-per-stage
// step sets the depth.
// When duty.ready is low with a beat waiting, the whole pipeline holds and
// cmd.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads wheel_base 3604 and wheel_radius
// 3801. The user must write configuration only while no command is in
// flight; the block does not enforce it. A wheel_radius of 0 acts as 1.
module differential_drive_duty_mixer #(
    parameter int DUTY_BITS = dmx_pkg::DMX_DUTY_BITS
) (
    input  logic  clk,
    input  logic  rst_n,
    dmx_cmd_if.sink    cmd,
    dmx_duty_if.source duty,
    dmx_cfg_if.sink    cfg
);
    import dmx_pkg::*;

    localparam int DP_W = DMX_MAG_W + DUTY_BITS + 8;
    localparam logic [DP_W-1:0] MAX_DUTY = (DP_W'(1) << DUTY_BITS) - DP_W'(1);

    logic en;
    logic out_vld_reg;

    assign en        = !out_vld_reg || duty.ready;
    assign cmd.ready = en;
    assign cfg.ready = 1'b1;

    // configuration
    logic [15:0] wb_reg, rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg  <= DMX_BASE_RST;
            rad_reg <= DMX_RADIUS_RST;
        end
        else if (cfg.valid)
        begin
            case (dmx_reg_t'(cfg.index))
                REG_WHEEL_BASE:   wb_reg  <= cfg.data;
                REG_WHEEL_RADIUS: rad_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // stage 1: capture, clamp power
    logic                        p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [2:0]                  p1_act_reg, p2_act_reg, p3_act_reg;
    logic signed [DMX_PWR_W-1:0] p1_pwr_reg, p2_pwr_reg, p3_pwr_reg;
    logic signed [15:0]          p1_lin_reg, p2_lin_reg, p1_turn_reg;
    logic [15:0]                 p1_wb_reg, p1_rad_reg, p2_rad_reg, p3_rad_reg;
    logic signed [32:0]          p2_prod_reg;
    logic [DMX_SPD_W-1:0]        p3_mag_reg [DMX_LANES];
    logic [DMX_LANES-1:0]        p3_neg_reg;
    logic signed [DMX_PWR_W-1:0] pwr_next;

    always_comb
    begin
        if (cmd.power > 16'sd4096)
            pwr_next = DMX_PWR_W'(DMX_ONE_Q12);
        else if (cmd.power < -16'sd4096)
            pwr_next = -DMX_PWR_W'(DMX_ONE_Q12);
        else
            pwr_next = cmd.power[DMX_PWR_W-1:0];
    end

    // stage 3: numerators
    logic signed [36:0] num_l, num_r;

    always_comb
    begin
        num_l = 37'(signed'({p2_lin_reg, 16'b0})) - (37'(p2_prod_reg) <<< 3);
        num_r = 37'(signed'({p2_lin_reg, 16'b0})) + (37'(p2_prod_reg) <<< 3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= cmd.valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_act_reg  <= cmd.action;
            p1_lin_reg  <= cmd.linear_speed;
            p1_turn_reg <= cmd.turn_rate;
            p1_pwr_reg  <= pwr_next;
            p1_wb_reg   <= wb_reg;
            p1_rad_reg  <= (rad_reg == 16'd0) ? 16'd1 : rad_reg;

            p2_act_reg  <= p1_act_reg;
            p2_pwr_reg  <= p1_pwr_reg;
            p2_lin_reg  <= p1_lin_reg;
            p2_rad_reg  <= p1_rad_reg;
            p2_prod_reg <= signed'({1'b0, p1_wb_reg}) * p1_turn_reg;

            p3_act_reg    <= p2_act_reg;
            p3_pwr_reg    <= p2_pwr_reg;
            p3_rad_reg    <= p2_rad_reg;
            p3_neg_reg[0] <= num_l[36];
            p3_neg_reg[1] <= num_r[36];
            p3_mag_reg[0] <= num_l[36] ? DMX_SPD_W'(-num_l) : num_l[DMX_SPD_W-1:0];
            p3_mag_reg[1] <= num_r[36] ? DMX_SPD_W'(-num_r) : num_r[DMX_SPD_W-1:0];
        end
    end

    // wheel speed divider
    dmx_sb1_t             sb1_in, sb1_out;
    logic [15:0]          d1_rem [DMX_LANES];
    logic [DMX_SPD_W-1:0] d1_quo [DMX_LANES];
    logic                 d1_vld;

    assign sb1_in = '{action: p3_act_reg, pwr: p3_pwr_reg, neg: p3_neg_reg};
    assign d1_rem[0] = '0;
    assign d1_rem[1] = '0;

    dmx_div #(
        .DEN_W (16),
        .Q_W   (DMX_SPD_W),
        .STEPS (DMX_DIV_STEPS),
        .SB_W  ($bits(dmx_sb1_t))
    ) u_div_spd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p3_vld_reg),
        .in_den    (p3_rad_reg),
        .in_rem    (d1_rem),
        .in_low    (p3_mag_reg),
        .in_sb     (sb1_in),
        .out_valid (d1_vld),
        .out_quo   (d1_quo),
        .out_sb    (sb1_out)
    );

    // stage: max magnitude, normalize decision
    logic                 p4_vld_reg, p4_scale_reg;
    logic [DMX_SPD_W-1:0] p4_q_reg [DMX_LANES];
    logic [DMX_SPD_W-1:0] p4_m_reg;
    dmx_sb1_t             p4_sb_reg;
    logic [DMX_SPD_W-1:0] m_next;

    assign m_next = (d1_quo[0] > d1_quo[1]) ? d1_quo[0] : d1_quo[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_vld_reg <= 1'b0;
        else if (en)
            p4_vld_reg <= d1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_q_reg[0]  <= d1_quo[0];
            p4_q_reg[1]  <= d1_quo[1];
            p4_m_reg     <= m_next;
            p4_scale_reg <= m_next > DMX_SPD_W'(DMX_ONE_Q12);
            p4_sb_reg    <= sb1_out;
        end
    end

    // normalize divider: q * 4096 / m
    dmx_sb2_t             sb2_in, sb2_out;
    logic [DMX_SPD_W-1:0] d2_rem [DMX_LANES];
    logic [DMX_MAG_W-1:0] d2_low [DMX_LANES];
    logic [DMX_MAG_W-1:0] d2_quo [DMX_LANES];
    logic                 d2_vld;

    for (genvar l = 0; l < DMX_LANES; l++)
    begin : g_d2
        assign d2_rem[l] = {1'b0, p4_q_reg[l][DMX_SPD_W-1:1]};
        assign d2_low[l] = {p4_q_reg[l][0], 12'b0};
    end

    assign sb2_in = '{cmd: p4_sb_reg, scale: p4_scale_reg,
                      raw_l: p4_q_reg[0][DMX_MAG_W-1:0],
                      raw_r: p4_q_reg[1][DMX_MAG_W-1:0]};

    dmx_div #(
        .DEN_W (DMX_SPD_W),
        .Q_W   (DMX_MAG_W),
        .STEPS (DMX_DIV_STEPS),
        .SB_W  ($bits(dmx_sb2_t))
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p4_vld_reg),
        .in_den    (p4_m_reg),
        .in_rem    (d2_rem),
        .in_low    (d2_low),
        .in_sb     (sb2_in),
        .out_valid (d2_vld),
        .out_quo   (d2_quo),
        .out_sb    (sb2_out)
    );

    // duty forming
    logic [7:0] lf_next, lb_next, rf_next, rb_next;
    logic [7:0] lf_reg, lb_reg, rf_reg, rb_reg;

    always_comb
    begin
        logic [DMX_MAG_W-1:0] mag   [DMX_LANES];
        logic [DMX_LANES-1:0] neg, swap;
        logic [DP_W-1:0]      dp;
        logic [7:0]           d     [DMX_LANES];
        logic [7:0]           fwd   [DMX_LANES];
        logic [7:0]           bwd   [DMX_LANES];
        logic                 stop;
        logic [DMX_PWR_W-1:0] pmag;

        pmag = sb2_out.cmd.pwr[DMX_PWR_W-1] ? DMX_PWR_W'(-sb2_out.cmd.pwr)
                                             : DMX_PWR_W'(sb2_out.cmd.pwr);
        stop = 1'b0;
        swap = '0;
        case (dmx_action_t'(sb2_out.cmd.action))
            ACT_MOVE:
            begin
                mag[0] = sb2_out.scale ? d2_quo[0] : sb2_out.raw_l;
                mag[1] = sb2_out.scale ? d2_quo[1] : sb2_out.raw_r;
                neg    = sb2_out.cmd.neg;
            end
            ACT_FWD, ACT_BWD, ACT_LEFT, ACT_RIGHT:
            begin
                mag[0] = pmag[DMX_MAG_W-1:0];
                mag[1] = pmag[DMX_MAG_W-1:0];
                neg    = {DMX_LANES{sb2_out.cmd.pwr[DMX_PWR_W-1]}};
                swap[0] = (sb2_out.cmd.action == ACT_BWD) || (sb2_out.cmd.action == ACT_RIGHT);
                swap[1] = (sb2_out.cmd.action == ACT_BWD) || (sb2_out.cmd.action == ACT_LEFT);
            end
            default:
            begin
                mag[0] = '0;
                mag[1] = '0;
                neg    = '0;
                stop   = 1'b1;
            end
        endcase

        for (int l = 0; l < DMX_LANES; l++)
        begin
            dp   = (DP_W'(mag[l]) * MAX_DUTY) >> 12;
            d[l] = stop ? 8'd0 : dp[7:0];
            if (swap[l] ^ neg[l])
            begin
                fwd[l] = 8'd0;
                bwd[l] = d[l];
            end
            else
            begin
                fwd[l] = d[l];
                bwd[l] = 8'd0;
            end
        end
        lf_next = fwd[0];
        lb_next = bwd[0];
        rf_next = fwd[1];
        rb_next = bwd[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lf_reg <= lf_next;
            lb_reg <= lb_next;
            rf_reg <= rf_next;
            rb_reg <= rb_next;
        end
    end

    assign duty.valid               = out_vld_reg;
    assign duty.left_forward_duty   = lf_reg;
    assign duty.left_backward_duty  = lb_reg;
    assign duty.right_forward_duty  = rf_reg;
    assign duty.right_backward_duty = rb_reg;

endmodule

// ===== rtl/core/dmx_checker.sv =====
// Checker: port-level properties of the duty mixer, bound to the top level.
module dmx_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] lf,
    input logic [7:0] lb,
    input logic [7:0] rf,
    input logic [7:0] rb
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("duty beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(lf) && $stable(lb) && $stable(rf) && $stable(rb))
        else $error("duty beat changed while stalled");

    a_left_pin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lf == 8'd0) || (lb == 8'd0))
        else $error("left motor drives both pins");

    a_right_pin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rf == 8'd0) || (rb == 8'd0))
        else $error("right motor drives both pins");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("command taken while output stalled");
endmodule

bind differential_drive_duty_mixer dmx_checker u_dmx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (cmd.ready),
    .out_valid (duty.valid),
    .out_ready (duty.ready),
    .lf        (duty.left_forward_duty),
    .lb        (duty.left_backward_duty),
    .rf        (duty.right_forward_duty),
    .rb        (duty.right_backward_duty)
);

// ===== verif/differential_drive_duty_mixer_tb.sv =====
// Testbench: random and directed command beats against a duty predictor.
module differential_drive_duty_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dmx_pkg::*;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_rate;
        logic signed [15:0] power;
    } cmd_t;

    typedef struct packed {
        logic [7:0] lf;
        logic [7:0] lb;
        logic [7:0] rf;
        logic [7:0] rb;
    } duties_t;

    localparam int LATENCY = 25;
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk;
    logic rst_n;

    dmx_cmd_if  cmd ();
    dmx_duty_if duty ();
    dmx_cfg_if  cfg ();

    differential_drive_duty_mixer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .duty  (duty.source),
        .cfg   (cfg.sink)
    );

    cmd_t    pending_cmds[$];
    duties_t expected_duties[$];
    logic [15:0] base_q16;
    logic [15:0] radius_q16;
    int errors;
    int cmds_sent;
    int duties_seen;
    int idle_cycles;
    bit stim_done;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void motor_duty(input longint speed, input bit swap,
                                       output logic [7:0] fwd, output logic [7:0] bwd);
        longint mag;
        logic [7:0] d;
        logic [7:0] a;
        logic [7:0] b;
        mag = speed < 0 ? -speed : speed;
        d = 8'((mag * 255) / DMX_ONE_Q12);
        a = speed > 0 ? d : 8'd0;
        b = speed < 0 ? d : 8'd0;
        fwd = swap ? b : a;
        bwd = swap ? a : b;
    endfunction

    function automatic duties_t mix_duties(input cmd_t c);
        longint lin, trn, pwr, r, base, diff, left, right, ml, mr, m;
        bit swap_l;
        bit swap_r;
        duties_t d;
        lin = c.linear_speed;
        trn = c.turn_rate;
        pwr = c.power;
        left = 0;
        right = 0;
        swap_l = 0;
        swap_r = 0;
        if (pwr > DMX_ONE_Q12)
            pwr = DMX_ONE_Q12;
        if (pwr < -DMX_ONE_Q12)
            pwr = -DMX_ONE_Q12;
        case (c.action)
            ACT_MOVE: begin
                r = radius_q16 == 0 ? 1 : longint'(radius_q16);
                base = lin * 65536;
                diff = 8 * longint'(base_q16) * trn;
                left = (base - diff) / r;
                right = (base + diff) / r;
                ml = left < 0 ? -left : left;
                mr = right < 0 ? -right : right;
                m = ml > mr ? ml : mr;
                if (m > DMX_ONE_Q12)
                begin
                    left = (left * DMX_ONE_Q12) / m;
                    right = (right * DMX_ONE_Q12) / m;
                end
            end
            ACT_FWD: begin
                left = pwr;
                right = pwr;
            end
            ACT_BWD: begin
                left = pwr;
                right = pwr;
                swap_l = 1;
                swap_r = 1;
            end
            ACT_LEFT: begin
                left = pwr;
                right = pwr;
                swap_r = 1;
            end
            ACT_RIGHT: begin
                left = pwr;
                right = pwr;
                swap_l = 1;
            end
            default: ;
        endcase
        motor_duty(left, swap_l, d.lf, d.lb);
        motor_duty(right, swap_r, d.rf, d.rb);
        return d;
    endfunction

    // driver
    int cmd_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            cmd_gap = 0;
        end
        else begin
            if (cmd.valid && cmd.ready)
            begin
                expected_duties.push_back(mix_duties({cmd.action, cmd.linear_speed,
                                                      cmd.turn_rate, cmd.power}));
                cmds_sent++;
                cmd_gap = gap_len();
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (cmd_gap > 0)
                begin
                    cmd_gap--;
                    cmd.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    cmd.valid        <= 1'b1;
                    cmd.action       <= c.action;
                    cmd.linear_speed <= c.linear_speed;
                    cmd.turn_rate    <= c.turn_rate;
                    cmd.power        <= c.power;
                end
                else
                    cmd.valid <= 1'b0;
            end
        end
    end

    // monitor and sink stalls
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty.ready <= 1'b0;
            stall = 0;
        end
        else begin
            if (duty.valid && duty.ready)
            begin
                duties_t exp_d;
                duties_seen++;
                if (expected_duties.size() == 0)
                begin
                    $error("duty beat with nothing expected");
                    errors++;
                end
                else begin
                    exp_d = expected_duties.pop_front();
                    if (duty.left_forward_duty !== exp_d.lf)
                    begin
                        $error("left_forward_duty exp %0d got %0d", exp_d.lf,
                               duty.left_forward_duty);
                        errors++;
                    end
                    if (duty.left_backward_duty !== exp_d.lb)
                    begin
                        $error("left_backward_duty exp %0d got %0d", exp_d.lb,
                               duty.left_backward_duty);
                        errors++;
                    end
                    if (duty.right_forward_duty !== exp_d.rf)
                    begin
                        $error("right_forward_duty exp %0d got %0d", exp_d.rf,
                               duty.right_forward_duty);
                        errors++;
                    end
                    if (duty.right_backward_duty !== exp_d.rb)
                    begin
                        $error("right_backward_duty exp %0d got %0d", exp_d.rb,
                               duty.right_backward_duty);
                        errors++;
                    end
                end
            end
            if (stall > 0)
            begin
                stall--;
                duty.ready <= 1'b0;
            end
            else begin
                stall = gap_len();
                duty.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (duty.valid && duty.ready)
            || (cfg.valid && cfg.ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[differential_drive_duty_mixer] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input dmx_reg_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_WHEEL_BASE)
            base_q16 = value;
        else
            radius_q16 = value;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || cmd.valid || expected_duties.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_s16();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 8192)) - 16'sd4096;
            3: return 16'($urandom_range(0, 512)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random(input int n);
        cmd_t c;
        repeat (n)
        begin
            c.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                       : 3'($urandom_range(0, 5));
            c.linear_speed = rand_s16();
            c.turn_rate = rand_s16();
            c.power = rand_s16();
            pending_cmds.push_back(c);
        end
    endtask

    task automatic add_directed();
        logic signed [15:0] vals[6];
        vals = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd4096, -16'sd4096, 16'sd1};
        for (int a = 0; a < 8; a++)
            pending_cmds.push_back({3'(a), vals[a % 6], vals[(a + 2) % 6], vals[a % 6]});
        for (int a = ACT_FWD; a <= ACT_RIGHT; a++)
        begin
            pending_cmds.push_back({3'(a), 16'sd0, 16'sd0, 16'sd4097});
            pending_cmds.push_back({3'(a), 16'sd0, 16'sd0, -16'sd2048});
            pending_cmds.push_back({3'(a), 16'sd0, 16'sd0, 16'sd0});
        end
        pending_cmds.push_back({ACT_MOVE, 16'sd100, 16'sd0, 16'sd0});
        pending_cmds.push_back({ACT_MOVE, 16'sd0, 16'sd50, 16'sd0});
        pending_cmds.push_back({ACT_MOVE, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
        pending_cmds.push_back({ACT_MOVE, 16'sh8000, 16'sh7FFF, 16'sh8000});
    endtask

    initial begin
        logic [15:0] bases[5];
        logic [15:0] radii[5];
        bases = '{16'd3604, 16'd0, 16'hFFFF, 16'd1, 16'd3604};
        radii = '{16'd3801, 16'd1, 16'hFFFF, 16'd0, 16'd20000};
        errors = 0;
        cmds_sent = 0;
        duties_seen = 0;
        idle_cycles = 0;
        stim_done = 0;
        base_q16 = DMX_BASE_RST;
        radius_q16 = DMX_RADIUS_RST;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.action = '0;
        cmd.linear_speed = '0;
        cmd.turn_rate = '0;
        cmd.power = '0;
        duty.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        add_directed();
        drain();
        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_WHEEL_BASE, bases[p]);
            write_reg(REG_WHEEL_RADIUS, radii[p]);
            add_random(200);
            drain();
        end
        write_reg(REG_WHEEL_BASE, 16'($urandom));
        write_reg(REG_WHEEL_RADIUS, 16'($urandom));
        add_random(100);
        drain();
        stim_done = 1;
        $display("Ran %0d commands, %0d duty beats, over 6 geometry settings.",
                 cmds_sent, duties_seen);
        if (errors == 0)
            $display("[differential_drive_duty_mixer] OK");
        else
            $display("[differential_drive_duty_mixer] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/dmx_pkg.sv
rtl/core/dmx_cmd_if.sv
rtl/core/dmx_duty_if.sv
rtl/core/dmx_cfg_if.sv
rtl/core/dmx_div.sv
rtl/core/differential_drive_duty_mixer.sv
rtl/core/dmx_checker.sv
verif/differential_drive_duty_mixer_tb.sv
